FILE: src/rst_pkg.sv
package rst_pkg;

    localparam logic [1:0] REQ_ARRIVAL  = 2'd0;
    localparam logic [1:0] REQ_OUTCOME  = 2'd1;
    localparam logic [1:0] REQ_TICK     = 2'd2;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    localparam logic [1:0] OC_NONE     = 2'd0;
    localparam logic [1:0] OC_REFRESH  = 2'd1;
    localparam logic [1:0] OC_COMPLETE = 2'd2;
    localparam logic [1:0] OC_ERROR    = 2'd3;

    localparam logic [2:0] ST_ALLOC    = 3'd0;
    localparam logic [2:0] ST_FOUND    = 3'd1;
    localparam logic [2:0] ST_REPLACED = 3'd2;
    localparam logic [2:0] ST_REJECTED = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    localparam logic CFG_IDLE_LIMIT = 1'b0;
    localparam logic CFG_AGE_LIMIT  = 1'b1;

    localparam logic [31:0] IDLE_LIMIT_RESET = 32'd10000;
    localparam logic [31:0] AGE_LIMIT_RESET  = 32'd15000;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] sess_id;
        logic [8:0]  slot_index;
        logic [1:0]  outcome;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [8:0]  slot;
        logic [31:0] displaced_session;
        logic [9:0]  expired_slots;
        logic [6:0]  history_fill;
    } rsp_t;

endpackage

FILE: src/rst_req_if.sv
interface rst_req_if;
    import rst_pkg::*;
    logic valid;
    logic ready;
    req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: src/rst_rsp_if.sv
interface rst_rsp_if;
    import rst_pkg::*;
    logic valid;
    logic ready;
    rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: src/reassembly_session_table.sv
// Session table with SLOTS slots and a HISTORY_DEPTH ring of closed ids. Each
// transaction is handled by one sequencer that walks the slot and history
// memories one entry at a time through a single 32-bit subtract unit. An
// arrival checks the history ring, then scans the slots for a match, for a
// free slot and for the oldest slot, then replaces that slot and gives the
// result, stopping as soon as one step settles it; a tick expires idle slots
// and then pops aged history entries; an outcome acts on a single slot. One
// request is handled at a time; the result is held in an output register
// until taken, and the next request is accepted the cycle after that. Active
// bits are flip-flops cleared by reset, so there is no clearing pass.
module reassembly_session_table
    import rst_pkg::*;
#(
    parameter int SLOTS = 512,
    parameter int HISTORY_DEPTH = 64
)(
    input  logic        clk,
    input  logic        rst_n,
    rst_req_if.sink     req,
    rst_rsp_if.source   rsp,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SCW = $clog2(SLOTS + 1);
    localparam int HCW = $clog2(HISTORY_DEPTH + 1);

    localparam logic [3:0] S_IDLE = 4'd0, S_HSCAN = 4'd1, S_HCMP = 4'd2,
        S_MSCAN = 4'd3, S_MCMP = 4'd4, S_FREE = 4'd5, S_OSCAN = 4'd6,
        S_OCMP = 4'd7, S_REPL = 4'd8, S_TSCAN = 4'd9, S_TCMP = 4'd10,
        S_PSCAN = 4'd11, S_PCMP = 4'd12, S_OUT = 4'd13, S_OUTC = 4'd14;

    logic [31:0] idle_reg, age_reg;
    logic [3:0] state_reg;
    req_t r_reg;
    logic [SCW-1:0] idx_reg;
    logic [HCW-1:0] hidx_reg;
    logic [SW-1:0] best_reg;
    logic [31:0] best_time_reg;
    logic [9:0] exp_reg;
    logic [HW-1:0] head_reg, tail_reg;
    logic [HCW-1:0] count_reg;
    logic [SLOTS-1:0] active_reg;
    logic out_valid_reg;
    rsp_t out_reg;

    logic [31:0] slot_session_mem [SLOTS];
    logic [31:0] slot_time_mem [SLOTS];
    logic [31:0] hist_session_mem [HISTORY_DEPTH];
    logic [31:0] hist_time_mem [HISTORY_DEPTH];
    logic [31:0] rd_sess_reg, rd_time_reg, rd_hs_reg, rd_ht_reg;
    logic [SW-1:0] cur_reg;

    // Slot memory write port and history push, driven by the sequencer.
    logic s_we;
    logic [SW-1:0] s_waddr;
    logic [31:0] s_wsess, s_wtime;
    logic s_wsess_en;
    logic h_push;
    logic [31:0] h_id;

    logic [SW-1:0] idx_s;
    logic [HW:0] hsum;
    logic [HW-1:0] hrd;
    logic [31:0] diff;

    assign idx_s = idx_reg[SW-1:0];
    // The sum stays below 2*HISTORY_DEPTH, so one subtraction wraps it.
    assign hsum = (HW+1)'(head_reg) + (HW+1)'(hidx_reg);
    assign hrd = (hsum >= (HW+1)'(HISTORY_DEPTH)) ?
        HW'(hsum - (HW+1)'(HISTORY_DEPTH)) : HW'(hsum);
    assign req.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.payload = out_reg;

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            slot_time_mem[s_waddr] <= s_wtime;
            if (s_wsess_en)
                slot_session_mem[s_waddr] <= s_wsess;
        end
        rd_sess_reg <= slot_session_mem[idx_s];
        rd_time_reg <= slot_time_mem[idx_s];
        cur_reg <= idx_s;
        if (h_push)
        begin
            hist_session_mem[tail_reg] <= h_id;
            hist_time_mem[tail_reg] <= r_reg.now;
        end
        rd_hs_reg <= hist_session_mem[hrd];
        rd_ht_reg <= hist_time_mem[head_reg];
    end

    // Shared subtract unit: modular age of the entry just read.
    always_comb
    begin
        if (state_reg == S_PCMP)
            diff = r_reg.now - rd_ht_reg;
        else
            diff = r_reg.now - rd_time_reg;
    end

    always_comb
    begin
        s_we = 1'b0;
        s_waddr = idx_s;
        s_wsess = r_reg.sess_id;
        s_wtime = '0;
        s_wsess_en = 1'b1;
        h_push = 1'b0;
        h_id = rd_sess_reg;
        case (state_reg)
            S_FREE:
            begin
                if (idx_reg < SCW'(SLOTS) && !active_reg[idx_s])
                    s_we = 1'b1;
            end
            S_REPL:
            begin
                if (cur_reg == best_reg)
                begin
                    s_we = 1'b1;
                    s_waddr = best_reg;
                    h_push = 1'b1;
                end
            end
            S_OUTC:
            begin
                if (r_reg.outcome == OC_REFRESH)
                begin
                    s_we = 1'b1;
                    s_waddr = r_reg.slot_index[SW-1:0];
                    s_wtime = r_reg.now;
                    s_wsess_en = 1'b0;
                end
                else if (r_reg.outcome != OC_NONE && cur_reg == idx_s
                         && active_reg[idx_s])
                    h_push = 1'b1;
            end
            S_TCMP:
            begin
                if (active_reg[cur_reg] && diff >= idle_reg)
                    h_push = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg <= IDLE_LIMIT_RESET;
            age_reg <= AGE_LIMIT_RESET;
            state_reg <= S_IDLE;
            head_reg <= '0;
            tail_reg <= '0;
            count_reg <= '0;
            active_reg <= '0;
            out_valid_reg <= 1'b0;
            idx_reg <= '0;
            hidx_reg <= '0;
            exp_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_IDLE_LIMIT)
                    idle_reg <= cfg_wdata;
                else
                    age_reg <= cfg_wdata;
            end
            if (rsp.valid && rsp.ready)
                out_valid_reg <= 1'b0;
            if (h_push)
            begin
                tail_reg <= (32'(tail_reg) + 1 >= HISTORY_DEPTH) ? '0 : tail_reg + 1'b1;
                if (count_reg >= HCW'(HISTORY_DEPTH))
                    head_reg <= (32'(head_reg) + 1 >= HISTORY_DEPTH) ? '0 : head_reg + 1'b1;
                else
                    count_reg <= count_reg + 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        r_reg <= req.payload;
                        idx_reg <= '0;
                        hidx_reg <= '0;
                        exp_reg <= '0;
                        out_reg <= '{ST_DONE, 9'd0, 32'd0, 10'd0, 7'd0};
                        case (req.payload.req_type)
                            REQ_ARRIVAL: state_reg <= S_HSCAN;
                            REQ_OUTCOME:
                            begin
                                idx_reg <= SCW'(req.payload.slot_index[SW-1:0]);
                                if (32'(req.payload.slot_index) < SLOTS)
                                    state_reg <= S_OUTC;
                                else
                                    state_reg <= S_OUT;
                            end
                            REQ_TICK: state_reg <= S_TSCAN;
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_HSCAN:
                begin
                    if (hidx_reg >= count_reg)
                        state_reg <= S_MSCAN;
                    else
                        state_reg <= S_HCMP;
                end
                S_HCMP:
                begin
                    if (rd_hs_reg == r_reg.sess_id)
                    begin
                        out_reg.status <= ST_REJECTED;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        hidx_reg <= hidx_reg + 1'b1;
                        state_reg <= S_HSCAN;
                    end
                end
                S_MSCAN:
                begin
                    if (idx_reg >= SCW'(SLOTS))
                    begin
                        idx_reg <= '0;
                        state_reg <= S_FREE;
                    end
                    else
                        state_reg <= S_MCMP;
                end
                S_MCMP:
                begin
                    if (active_reg[cur_reg] && rd_sess_reg == r_reg.sess_id)
                    begin
                        out_reg.status <= ST_FOUND;
                        out_reg.slot <= 9'(cur_reg);
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_MSCAN;
                    end
                end
                S_FREE:
                begin
                    if (idx_reg >= SCW'(SLOTS))
                    begin
                        idx_reg <= '0;
                        state_reg <= S_OSCAN;
                    end
                    else if (!active_reg[idx_s])
                    begin
                        active_reg[idx_s] <= 1'b1;
                        out_reg.status <= ST_ALLOC;
                        out_reg.slot <= 9'(idx_s);
                        state_reg <= S_OUT;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_OSCAN:
                begin
                    if (idx_reg >= SCW'(SLOTS))
                    begin
                        idx_reg <= SCW'(best_reg);
                        state_reg <= S_REPL;
                    end
                    else
                        state_reg <= S_OCMP;
                end
                S_OCMP:
                begin
                    if (cur_reg == '0 || rd_time_reg < best_time_reg)
                    begin
                        best_reg <= cur_reg;
                        best_time_reg <= rd_time_reg;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    state_reg <= S_OSCAN;
                end
                S_REPL:
                begin
                    // Slot session read for best_reg arrives this cycle.
                    if (cur_reg == best_reg)
                    begin
                        out_reg.status <= ST_REPLACED;
                        out_reg.slot <= 9'(best_reg);
                        out_reg.displaced_session <= rd_sess_reg;
                        state_reg <= S_OUT;
                    end
                end
                S_OUTC:
                begin
                    if (cur_reg == idx_s)
                    begin
                        if (active_reg[idx_s] && r_reg.outcome != OC_NONE
                            && r_reg.outcome != OC_REFRESH)
                            active_reg[idx_s] <= 1'b0;
                        state_reg <= S_OUT;
                    end
                end
                S_TSCAN:
                begin
                    if (idx_reg >= SCW'(SLOTS))
                        state_reg <= S_PSCAN;
                    else
                        state_reg <= S_TCMP;
                end
                S_TCMP:
                begin
                    if (active_reg[cur_reg] && diff >= idle_reg)
                    begin
                        active_reg[cur_reg] <= 1'b0;
                        exp_reg <= exp_reg + 1'b1;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    state_reg <= S_TSCAN;
                end
                S_PSCAN:
                begin
                    if (count_reg == '0)
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_PCMP;
                end
                S_PCMP:
                begin
                    if (diff >= age_reg)
                    begin
                        head_reg <= (32'(head_reg) + 1 >= HISTORY_DEPTH) ? '0 : head_reg + 1'b1;
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_PSCAN;
                    end
                    else
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    out_reg.expired_slots <= exp_reg;
                    out_reg.history_fill <= 7'(count_reg);
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // S_REPL/S_OUTC: the read address is set on entry and cur_reg follows it in
    // the next cycle; the slot write and the history push wait until cur_reg matches.

`ifndef SYNTHESIS
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= HCW'(HISTORY_DEPTH)) else $error("history count overflow");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !req.ready) else $error("ready while result pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |=> out_valid_reg) else $error("result dropped");
`endif
endmodule

FILE: dv/rst_tb_if.sv
`timescale 1ns / 100ps

// The block's own interface files are compiled with the RTL; this file holds
// the testbench scoreboard class so that the top module stays focused on driving.
package rst_tb_pkg;
    import rst_pkg::*;

    localparam int NUM_SLOTS = 512;
    localparam int HIST_DEPTH = 64;

    class session_scoreboard;
        bit          active [NUM_SLOTS];
        logic [31:0] sess [NUM_SLOTS];
        logic [31:0] stamp [NUM_SLOTS];
        logic [31:0] hist_sess [HIST_DEPTH];
        logic [31:0] hist_stamp [HIST_DEPTH];
        int          head;
        int          tail;
        int          count;
        logic [31:0] idle_limit;
        logic [31:0] age_limit;
        rsp_t        pending [$];
        int          mismatches;

        function void reset_state();
            foreach (active[i]) active[i] = 0;
            head = 0;
            tail = 0;
            count = 0;
            idle_limit = IDLE_LIMIT_RESET;
            age_limit = AGE_LIMIT_RESET;
        endfunction

        function void write_reg(logic index, logic [31:0] value);
            if (index == CFG_IDLE_LIMIT)
                idle_limit = value;
            else
                age_limit = value;
        endfunction

        function void push_closed(logic [31:0] id, logic [31:0] t);
            hist_sess[tail] = id;
            hist_stamp[tail] = t;
            tail = (tail + 1) % HIST_DEPTH;
            if (count >= HIST_DEPTH)
                head = (head + 1) % HIST_DEPTH;
            else
                count++;
        endfunction

        function bit recently_closed(logic [31:0] id);
            for (int i = 0; i < count; i++)
                if (hist_sess[(head + i) % HIST_DEPTH] == id)
                    return 1;
            return 0;
        endfunction

        // Computes the response for one accepted request and queues it.
        function void note_request(req_t r);
            rsp_t e;
            bit   placed;
            int   best;
            e = '0;
            e.status = ST_DONE;
            placed = 0;
            if (r.req_type == REQ_ARRIVAL)
            begin
                if (recently_closed(r.sess_id))
                begin
                    e.status = ST_REJECTED;
                end
                else
                begin
                    for (int i = 0; i < NUM_SLOTS && !placed; i++)
                        if (active[i] && sess[i] == r.sess_id)
                        begin
                            e.status = ST_FOUND;
                            e.slot = 9'(i);
                            placed = 1;
                        end
                    for (int i = 0; i < NUM_SLOTS && !placed; i++)
                        if (!active[i])
                        begin
                            active[i] = 1;
                            sess[i] = r.sess_id;
                            stamp[i] = 0;
                            e.status = ST_ALLOC;
                            e.slot = 9'(i);
                            placed = 1;
                        end
                    if (!placed)
                    begin
                        best = 0;
                        for (int i = 1; i < NUM_SLOTS; i++)
                            if (stamp[i] < stamp[best])
                                best = i;
                        e.displaced_session = sess[best];
                        push_closed(sess[best], r.now);
                        sess[best] = r.sess_id;
                        stamp[best] = 0;
                        e.status = ST_REPLACED;
                        e.slot = 9'(best);
                    end
                end
            end
            else if (r.req_type == REQ_OUTCOME)
            begin
                if (active[r.slot_index])
                begin
                    if (r.outcome == OC_REFRESH)
                        stamp[r.slot_index] = r.now;
                    else if (r.outcome != OC_NONE)
                    begin
                        active[r.slot_index] = 0;
                        push_closed(sess[r.slot_index], r.now);
                    end
                end
            end
            else if (r.req_type == REQ_TICK)
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (active[i] && (r.now - stamp[i]) >= idle_limit)
                    begin
                        active[i] = 0;
                        push_closed(sess[i], r.now);
                        e.expired_slots = e.expired_slots + 10'd1;
                    end
                while (count > 0 && (r.now - hist_stamp[head]) >= age_limit)
                begin
                    head = (head + 1) % HIST_DEPTH;
                    count--;
                end
            end
            e.history_fill = 7'(count);
            pending.push_back(e);
        endfunction

        function void check_response(rsp_t got);
            rsp_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %p", got);
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status || got.slot !== e.slot
                || got.displaced_session !== e.displaced_session
                || got.expired_slots !== e.expired_slots
                || got.history_fill !== e.history_fill)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response mismatch: expected %p, got %p", e, got);
            end
        endfunction
    endclass
endpackage

FILE: dv/reassembly_session_table_tb.sv
`timescale 1ns / 100ps

module reassembly_session_table_tb;
    import rst_pkg::*;
    import rst_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_wdata;
    int          idle_cycles;
    int          stall_phase;
    logic [31:0] clock_ms;
    logic [31:0] known_ids [$];
    session_scoreboard board;

    rst_req_if req ();
    rst_rsp_if rsp ();

    reassembly_session_table uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog: counts cycles with no transaction on either channel.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("reassembly_session_table regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            board.check_response(rsp.payload);
    end

    // The receiver stalls in a repeating pattern with a random-free stretch.
    always @(negedge clk)
    begin
        stall_phase <= (stall_phase + 1) % 97;
        if (stall_phase < 40)
            rsp.ready <= 1'b1;
        else
            rsp.ready <= ($urandom_range(0, 2) != 0);
    end

    task automatic send_request(req_t r);
        req.payload <= r;
        req.valid <= 1'b1;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        board.note_request(r);
        @(negedge clk);
    endtask

    task automatic pause_sender();
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
    endtask

    task automatic write_config(logic index, logic [31:0] value);
        while (board.pending.size() != 0)
            @(negedge clk);
        req.valid <= 1'b0;
        repeat (2000) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        board.write_reg(index, value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic req_t make_req(logic [1:0] kind, logic [31:0] id,
                                      logic [8:0] idx, logic [1:0] oc,
                                      logic [31:0] t);
        req_t r;
        r.req_type = kind;
        r.sess_id = id;
        r.slot_index = idx;
        r.outcome = oc;
        r.now = t;
        return r;
    endfunction

    function automatic logic [31:0] pick_id();
        if (known_ids.size() != 0 && $urandom_range(0, 3) != 0)
            return known_ids[$urandom_range(0, known_ids.size() - 1)];
        pick_id = $urandom();
        known_ids.push_back(pick_id);
        if (known_ids.size() > 80)
            void'(known_ids.pop_front());
    endfunction

    task automatic random_phase(int n);
        int burst;
        int kind;
        burst = $urandom_range(0, 12);
        for (int k = 0; k < n; k++)
        begin
            kind = $urandom_range(0, 99);
            clock_ms = clock_ms + $urandom_range(0, 3000);
            if (kind < 50)
                send_request(make_req(REQ_ARRIVAL, pick_id(), 9'($urandom()),
                                      2'($urandom()), clock_ms));
            else if (kind < 85)
                send_request(make_req(REQ_OUTCOME, $urandom(),
                                      9'(($urandom_range(0, 15) == 0) ? $urandom()
                                                                      : $urandom_range(0, 40)),
                                      2'($urandom()), clock_ms));
            else if (kind < 97)
                send_request(make_req(REQ_TICK, $urandom(), 9'($urandom()),
                                      2'($urandom()), clock_ms));
            else
                send_request(make_req(REQ_RESERVED, $urandom(), 9'($urandom()),
                                      2'($urandom()), $urandom()));
            if (burst == 0)
            begin
                pause_sender();
                burst = $urandom_range(0, 12);
            end
            else
                burst--;
        end
        req.valid <= 1'b0;
    endtask

    initial
    begin
        board = new();
        board.reset_state();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_IDLE_LIMIT;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.payload = '0;
        rsp.ready = 1'b0;
        idle_cycles = 0;
        stall_phase = 0;
        clock_ms = 32'd1000;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes of fields, every request kind and outcome.
        send_request(make_req(REQ_ARRIVAL, 32'h0, 9'd0, OC_NONE, 32'h0));
        send_request(make_req(REQ_ARRIVAL, 32'hFFFF_FFFF, 9'h1FF, OC_ERROR, 32'hFFFF_FFFF));
        send_request(make_req(REQ_ARRIVAL, 32'h0, 9'd5, OC_REFRESH, 32'd10));
        send_request(make_req(REQ_OUTCOME, 32'h0, 9'd1, OC_REFRESH, 32'd20));
        send_request(make_req(REQ_OUTCOME, 32'h0, 9'd0, OC_NONE, 32'd30));
        send_request(make_req(REQ_OUTCOME, 32'h0, 9'd0, OC_COMPLETE, 32'd40));
        send_request(make_req(REQ_ARRIVAL, 32'h0, 9'd0, OC_NONE, 32'd50));
        send_request(make_req(REQ_OUTCOME, 32'h0, 9'd1, OC_ERROR, 32'd60));
        send_request(make_req(REQ_OUTCOME, 32'h0, 9'h1FF, OC_ERROR, 32'd70));
        send_request(make_req(REQ_TICK, 32'h0, 9'd0, OC_NONE, 32'd80));
        send_request(make_req(REQ_TICK, 32'h0, 9'd0, OC_NONE, 32'hFFFF_FFF0));
        send_request(make_req(REQ_RESERVED, 32'hFFFF_FFFF, 9'h1FF, OC_ERROR, 32'hFFFF_FFFF));

        // Fill every slot, then force replacements; the last tick expires
        // every slot and wraps the history ring.
        for (int i = 0; i < NUM_SLOTS + 10; i++)
            send_request(make_req(REQ_ARRIVAL, 32'h8000_0000 + i, 9'd0, OC_NONE,
                                  32'd100 + i));
        send_request(make_req(REQ_OUTCOME, 32'h0, 9'd7, OC_REFRESH, 32'd5));
        send_request(make_req(REQ_TICK, 32'h0, 9'd0, OC_NONE, 32'd9000));
        send_request(make_req(REQ_TICK, 32'h0, 9'd0, OC_NONE, 32'd40000));

        clock_ms = 32'd50000;
        random_phase(20);
        write_config(CFG_IDLE_LIMIT, 32'd0);
        write_config(CFG_AGE_LIMIT, 32'hFFFF_FFFF);
        random_phase(15);
        write_config(CFG_IDLE_LIMIT, 32'hFFFF_FFFF);
        write_config(CFG_AGE_LIMIT, 32'd0);
        random_phase(15);
        write_config(CFG_IDLE_LIMIT, 32'd4000);
        write_config(CFG_AGE_LIMIT, 32'd6000);
        random_phase(20);

        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (2000) @(negedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("reassembly_session_table regression: pass");
        else
            $display("reassembly_session_table regression: fail");
        $finish;
    end
endmodule
